// File: sv/bmps_pkg.sv
// ----------------------------------------------------------------------------
// bmps_pkg
// types, codes and helpers shared by the bmp stream to rgb565 block
// ----------------------------------------------------------------------------
package bmps_pkg;

   localparam int MAX_DIM = 4096;
   localparam int QDEPTH  = 4;
   localparam int QAW     = 2;

   localparam logic [15:0] BM_SIGNATURE = 16'h4D42;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SIGNATURE = 3'd1,
      ERR_FORMAT    = 3'd2,
      ERR_DEPTH     = 3'd3,
      ERR_SIZE      = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_BODY,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_ERROR,
      OP_PIX24,
      OP_PIX1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] color;
      logic [7:0]  bits;
      logic [3:0]  count;
      logic        last;
      logic [15:0] pal0;
      logic [15:0] pal1;
      logic [12:0] width;
      logic [12:0] height;
      logic        one_bit;
      err_type     err;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [15:0] color;
      logic        color_index;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        one_bit_image;
      err_type     error_code;
      logic        last_pixel;
   } rsp_type;

   function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

// File: sv/bmps_req_if.sv
// ----------------------------------------------------------------------------
// bmps_req_if
// file byte channel
// ----------------------------------------------------------------------------
interface bmps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: sv/bmps_rsp_if.sv
// ----------------------------------------------------------------------------
// bmps_rsp_if
// result channel
// ----------------------------------------------------------------------------
interface bmps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [15:0] color;
   logic        color_index;
   logic [12:0] image_width;
   logic [12:0] image_height;
   logic        one_bit_image;
   logic [2:0]  error_code;
   logic        last_pixel;

   modport source (output valid, output kind, output pixel_x, output pixel_y,
                   output color, output color_index, output image_width,
                   output image_height, output one_bit_image, output error_code,
                   output last_pixel, input ready);
   modport sink   (input valid, input kind, input pixel_x, input pixel_y,
                   input color, input color_index, input image_width,
                   input image_height, input one_bit_image, input error_code,
                   input last_pixel, output ready);
endinterface

// File: sv/bmps_front.sv
// ----------------------------------------------------------------------------
// bmps_front
// header parser and row walker, one file byte per transfer, emits commands
// ----------------------------------------------------------------------------
module bmps_front (
   input  logic              clock,
   input  logic              reset,
   bmps_req_if.sink          req_bus,
   input  logic              q_full,
   output logic              push,
   output bmps_pkg::cmd_type cmd
);
   import bmps_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] dib_ff, dib_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic        bottom_ff, bottom_in;
   logic        one_ff, one_in;
   logic [15:0] pal0_ff, pal0_in;
   logic [15:0] pal1_ff, pal1_in;
   logic [15:0] pbg_ff, pbg_in;
   logic [12:0] row_ff, row_in;
   logic [13:0] bir_ff, bir_in;
   logic [12:0] col_ff, col_in;
   logic [1:0]  ph3_ff, ph3_in;
   logic        fmt_ff, fmt_in;
   logic        dep_ff, dep_in;
   logic [13:0] rowbytes_ff, rowbytes_in;

   logic        accept;
   logic [7:0]  b;
   logic [1:0]  k;
   logic [31:0] v;
   logic [31:0] vabs;
   logic        do_decide;
   err_type     err;
   logic [32:0] base;
   logic [32:0] poff;
   logic [12:0] yfull;
   logic        last_row;
   logic [12:0] rem;
   logic [3:0]  n;
   logic [13:0] three_w;
   logic [17:0] bits24;
   logic [14:0] bir_next;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;
   assign b             = req_bus.data_byte;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      offset_in   = offset_ff;
      dib_in      = dib_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bottom_in   = bottom_ff;
      one_in      = one_ff;
      pal0_in     = pal0_ff;
      pal1_in     = pal1_ff;
      pbg_in      = pbg_ff;
      row_in      = row_ff;
      bir_in      = bir_ff;
      col_in      = col_ff;
      ph3_in      = ph3_ff;
      fmt_in      = fmt_ff;
      dep_in      = dep_ff;
      rowbytes_in = rowbytes_ff;
      push        = 1'b0;
      cmd         = '0;
      cmd.op      = OP_HEADER;
      cmd.err     = ERR_NONE;
      do_decide   = 1'b0;
      err         = ERR_NONE;

      if (pos_ff < 32'd2)       k = pos_ff[1:0];
      else if (pos_ff < 32'd26) k = pos_ff[1:0] ^ 2'b10;
      else if (pos_ff < 32'd30) k = {1'b0, pos_ff[0]};
      else                      k = pos_ff[1:0] ^ 2'b10;
      v    = (k == 2'd0) ? {24'd0, b} : (shift_ff | ({24'd0, b} << {k, 3'b000}));
      vabs = v[31] ? (32'd0 - v) : v;

      base  = (dib_ff > 32'd12) ? ({1'b0, dib_ff} + 33'd14) : 33'd30;
      poff  = {1'b0, pos_ff} - base;
      yfull = bottom_ff ? (height_ff - 13'd1 - row_ff) : row_ff;
      last_row = ({1'b0, row_ff} + 14'd1) == {1'b0, height_ff};
      rem   = width_ff - col_ff;
      n     = (rem >= 13'd8) ? 4'd8 : rem[3:0];
      three_w  = {width_ff, 1'b0} + {1'b0, width_ff};
      bits24   = {width_ff, 4'b0000} + {1'b0, width_ff, 3'b000};
      bir_next = {1'b0, bir_ff} + 15'd1;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               shift_in = v;
               pos_in   = pos_ff + 32'd1;
               case (pos_ff)
                  32'd1: begin
                     if (v[15:0] != BM_SIGNATURE) begin
                        phase_in = PH_IDLE;
                        push     = 1'b1;
                        cmd.op   = OP_ERROR;
                        cmd.err  = ERR_SIGNATURE;
                     end
                  end
                  32'd13: offset_in = v;
                  32'd17: dib_in = v;
                  32'd21: width_in = (v == 32'd0 || v > 32'(MAX_DIM)) ? 13'd0 : v[12:0];
                  32'd25: begin
                     if (v[31]) bottom_in = 1'b0;
                     height_in = (vabs == 32'd0 || vabs > 32'(MAX_DIM)) ? 13'd0 : vabs[12:0];
                  end
                  32'd27: if (v != 32'd1) fmt_in = 1'b1;
                  32'd29: begin
                     if (v == 32'd1)       one_in = 1'b1;
                     else if (v == 32'd24) one_in = 1'b0;
                     else                  dep_in = 1'b1;
                     do_decide = (dib_ff <= 32'd12);
                  end
                  32'd33: begin
                     if (v != 32'd0) fmt_in = 1'b1;
                     do_decide = 1'b1;
                  end
                  default: ;
               endcase
               if (do_decide) begin
                  if (fmt_in)                                   err = ERR_FORMAT;
                  else if (dep_in)                              err = ERR_DEPTH;
                  else if (width_ff == 13'd0 || height_ff == 13'd0) err = ERR_SIZE;
                  push = 1'b1;
                  if (err != ERR_NONE) begin
                     phase_in = PH_IDLE;
                     cmd.op   = OP_ERROR;
                     cmd.err  = err;
                  end else begin
                     phase_in = PH_BODY;
                     row_in   = '0;
                     bir_in   = '0;
                     col_in   = '0;
                     ph3_in   = '0;
                     if (one_in)
                        rowbytes_in = {12'(({1'b0, width_ff} + 14'd31) >> 5), 2'b00};
                     else
                        rowbytes_in = {12'(({1'b0, bits24} + 19'd31) >> 5), 2'b00};
                     cmd.op      = OP_HEADER;
                     cmd.width   = width_ff;
                     cmd.height  = height_ff;
                     cmd.one_bit = one_in;
                  end
               end
            end
            PH_BODY: begin
               if (pos_ff != 32'hFFFF_FFFF) pos_in = pos_ff + 32'd1;
               if (pos_ff < offset_ff) begin
                  if ({1'b0, pos_ff} >= base && poff < 33'd8) begin
                     case (poff[1:0])
                        2'd0: pbg_in = {8'd0, b};
                        2'd1: pbg_in = {b, pbg_ff[7:0]};
                        2'd2: begin
                           if (poff[2]) pal1_in = to565(b, pbg_ff[15:8], pbg_ff[7:0]);
                           else         pal0_in = to565(b, pbg_ff[15:8], pbg_ff[7:0]);
                        end
                        default: ;
                     endcase
                  end
               end else begin
                  cmd.x    = col_ff[11:0];
                  cmd.y    = yfull[11:0];
                  cmd.pal0 = pal0_ff;
                  cmd.pal1 = pal1_ff;
                  if (one_ff) begin
                     if (n != 4'd0) begin
                        push      = 1'b1;
                        cmd.op    = OP_PIX1;
                        cmd.bits  = b;
                        cmd.count = n;
                        cmd.last  = last_row && ((col_ff + 13'(n)) == width_ff);
                        col_in    = col_ff + 13'(n);
                     end
                  end else if (bir_ff < three_w) begin
                     ph3_in = (ph3_ff == 2'd2) ? 2'd0 : ph3_ff + 2'd1;
                     case (ph3_ff)
                        2'd0: pbg_in = {8'd0, b};
                        2'd1: pbg_in = {b, pbg_ff[7:0]};
                        default: begin
                           push      = 1'b1;
                           cmd.op    = OP_PIX24;
                           cmd.color = to565(b, pbg_ff[15:8], pbg_ff[7:0]);
                           cmd.last  = last_row && ((col_ff + 13'd1) == width_ff);
                           col_in    = col_ff + 13'd1;
                        end
                     endcase
                  end
                  bir_in = bir_next[13:0];
                  if (bir_next >= {1'b0, rowbytes_ff}) begin
                     bir_in = '0;
                     col_in = '0;
                     ph3_in = '0;
                     row_in = row_ff + 13'd1;
                     if (({1'b0, row_ff} + 14'd1) >= {1'b0, height_ff}) phase_in = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase

         if (req_bus.end_of_file) begin
            phase_in    = PH_HEADER;
            pos_in      = '0;
            shift_in    = '0;
            offset_in   = '0;
            dib_in      = '0;
            width_in    = '0;
            height_in   = '0;
            bottom_in   = 1'b1;
            one_in      = 1'b0;
            pal0_in     = '0;
            pal1_in     = '0;
            pbg_in      = '0;
            row_in      = '0;
            bir_in      = '0;
            col_in      = '0;
            ph3_in      = '0;
            fmt_in      = 1'b0;
            dep_in      = 1'b0;
            rowbytes_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         shift_ff    <= '0;
         offset_ff   <= '0;
         dib_ff      <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         bottom_ff   <= 1'b1;
         one_ff      <= 1'b0;
         pal0_ff     <= '0;
         pal1_ff     <= '0;
         pbg_ff      <= '0;
         row_ff      <= '0;
         bir_ff      <= '0;
         col_ff      <= '0;
         ph3_ff      <= '0;
         fmt_ff      <= 1'b0;
         dep_ff      <= 1'b0;
         rowbytes_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         shift_ff    <= shift_in;
         offset_ff   <= offset_in;
         dib_ff      <= dib_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bottom_ff   <= bottom_in;
         one_ff      <= one_in;
         pal0_ff     <= pal0_in;
         pal1_ff     <= pal1_in;
         pbg_ff      <= pbg_in;
         row_ff      <= row_in;
         bir_ff      <= bir_in;
         col_ff      <= col_in;
         ph3_ff      <= ph3_in;
         fmt_ff      <= fmt_in;
         dep_ff      <= dep_in;
         rowbytes_ff <= rowbytes_in;
      end
   end

endmodule

// File: sv/bmps_fifo.sv
// ----------------------------------------------------------------------------
// bmps_fifo
// short command queue between parser and pixel expander
// ----------------------------------------------------------------------------
module bmps_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmps_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output bmps_pkg::cmd_type head
);
   import bmps_pkg::*;

   cmd_type          mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in;
   logic [QAW-1:0]   rd_ff, rd_in;
   logic [QAW:0]     fill_ff, fill_in;

   assign full  = (fill_ff == (QAW+1)'(QDEPTH));
   assign empty = (fill_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// File: sv/bmps_back.sv
// ----------------------------------------------------------------------------
// bmps_back
// expands queued commands into results, one per cycle unless empty or stalled
// ----------------------------------------------------------------------------
module bmps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  bmps_pkg::cmd_type head,
   output logic              pop,
   bmps_rsp_if.source        rsp_bus
);
   import bmps_pkg::*;

   rsp_type    rsp_ff, rsp_in;
   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       advance;
   logic       bit_val;

   assign advance = !valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_in   = rsp_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      bit_val  = head.bits[3'd7 - idx_ff];
      if (advance) begin
         valid_in = !empty;
         if (!empty) begin
            rsp_in            = '0;
            rsp_in.error_code = ERR_NONE;
            case (head.op)
               OP_HEADER: begin
                  rsp_in.kind          = KIND_HEADER;
                  rsp_in.image_width   = head.width;
                  rsp_in.image_height  = head.height;
                  rsp_in.one_bit_image = head.one_bit;
                  pop = 1'b1;
               end
               OP_ERROR: begin
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.error_code = head.err;
                  pop = 1'b1;
               end
               OP_PIX24: begin
                  rsp_in.kind       = KIND_PIXEL;
                  rsp_in.pixel_x    = head.x;
                  rsp_in.pixel_y    = head.y;
                  rsp_in.color      = head.color;
                  rsp_in.last_pixel = head.last;
                  pop = 1'b1;
               end
               default: begin
                  rsp_in.kind        = KIND_PIXEL;
                  rsp_in.pixel_x     = head.x + 12'(idx_ff);
                  rsp_in.pixel_y     = head.y;
                  rsp_in.color_index = bit_val;
                  rsp_in.color       = bit_val ? head.pal1 : head.pal0;
                  if ({1'b0, idx_ff} == head.count - 4'd1) begin
                     rsp_in.last_pixel = head.last;
                     pop    = 1'b1;
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.pixel_x       = rsp_ff.pixel_x;
   assign rsp_bus.pixel_y       = rsp_ff.pixel_y;
   assign rsp_bus.color         = rsp_ff.color;
   assign rsp_bus.color_index   = rsp_ff.color_index;
   assign rsp_bus.image_width   = rsp_ff.image_width;
   assign rsp_bus.image_height  = rsp_ff.image_height;
   assign rsp_bus.one_bit_image = rsp_ff.one_bit_image;
   assign rsp_bus.error_code    = rsp_ff.error_code;
   assign rsp_bus.last_pixel    = rsp_ff.last_pixel;

`ifndef ASSERT_OFF
   a_mid_cmd_queued: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> !empty && head.op == OP_PIX1)
      else $error("pixel expansion index set without a queued 1-bit command");
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.last_pixel |-> rsp_ff.kind == KIND_PIXEL)
      else $error("last pixel flag on a non-pixel result");
   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.kind == KIND_ERROR |-> rsp_ff.error_code != ERR_NONE)
      else $error("error result without an error code");
`endif

endmodule

// File: sv/bmp_stream_to_rgb565_top.sv
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_top
// bmp file byte stream to rgb565 pixel stream
// ----------------------------------------------------------------------------
// path: commands are queued, then the expander registers each result
// throughput: one byte per cycle while the queue is not full; a 1-bit byte
//   gives up to 8 expander results, one per cycle while the output is ready
// reset: synchronous, clears parser state, queue pointers and result valid flag
module bmp_stream_to_rgb565_top (
   input  logic       clock,
   input  logic       reset,
   bmps_req_if.sink   req_bus,
   bmps_rsp_if.source rsp_bus
);
   import bmps_pkg::*;

   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   cmd_type push_cmd;
   cmd_type head;

   bmps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (full),
      .push    (push),
      .cmd     (push_cmd)
   );

   bmps_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   bmps_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (empty),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
